FILE: hw/rtl/block_map_allocator_macros.svh
// Assertion macros for the block map allocator.
// BMA_ASSERT is gated off while reset is held; BMA_ASSERT_RST also checks during reset.
`ifndef BLOCK_MAP_ALLOCATOR_MACROS_SVH
`define BLOCK_MAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define BMA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("block_map_allocator assertion failed");
`define BMA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("block_map_allocator reset assertion failed");
`else
`define BMA_ASSERT(lbl, prop)
`define BMA_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: hw/rtl/bma_pkg.sv
`default_nettype none

package bma_pkg;

  localparam int unsigned BLOCKS     = 1024;
  localparam int unsigned IDX_W      = $clog2(BLOCKS);
  localparam int unsigned CNT_W      = $clog2(BLOCKS + 1);
  localparam int unsigned SIZE_W     = 24;
  localparam int unsigned BB_W       = 13;
  localparam int unsigned USED_W     = 11;
  localparam int unsigned BB_MAX     = 4096;
  localparam logic [BB_W-1:0] BB_RESET = 13'd64;
  localparam int unsigned DIV_CNT_W  = $clog2(SIZE_W);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FAIL      = 2'd1,
    STAT_NOT_READY = 2'd2,
    STAT_RANGE     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_DIV,
    ST_SCAN,
    ST_FILL,
    ST_FREE_RD,
    ST_FREE_LEN,
    ST_QUERY,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [SIZE_W-1:0] size_bytes;
    logic [SIZE_W-1:0] offset_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SIZE_W-1:0] alloc_offset;
    logic [USED_W-1:0] used_blocks;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] quotient;
    logic              rem_nz;
  } div_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bma_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The result holds until the next start.
module bma_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bma_pkg::SIZE_W-1:0]  dividend_i,
  input  wire logic [bma_pkg::BB_W-1:0]    divisor_i,
  output logic                             done_o,
  output bma_pkg::div_res_t                res_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [bma_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [bma_pkg::SIZE_W-1:0]     dvd_q, dvd_d;
  logic [bma_pkg::BB_W-1:0]       rem_q, rem_d;
  logic [bma_pkg::BB_W:0]         rem_sh;
  logic                           ge;

  assign rem_sh = {rem_q, dvd_q[bma_pkg::SIZE_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = bma_pkg::DIV_CNT_W'(bma_pkg::SIZE_W - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // The dividend register shifts out numerator bits and shifts in quotient bits.
      dvd_d = {dvd_q[bma_pkg::SIZE_W-2:0], ge};
      rem_d = ge ? bma_pkg::BB_W'(rem_sh - {1'b0, divisor_i})
                 : bma_pkg::BB_W'(rem_sh);
      cnt_d = cnt_q - bma_pkg::DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o          = done_q;
  assign res_o.quotient  = dvd_q;
  assign res_o.rem_nz    = rem_q != '0;

endmodule

`default_nettype wire

FILE: hw/rtl/block_map_allocator.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_item_i   (bma_pkg::in_item_t)
// out       output     out_valid_o / out_stall_i out_item_o  (bma_pkg::out_item_t)
// cfg       input      cfg_we_i                  cfg_wdata_i (block_bytes)
//
// One command at a time: a dispatch state, then a division for an allocate or free that
// passes dispatch. An allocate scans the map memory through its read port and then
// writes its run at one entry per cycle; a free writes one entry per cycle, and a query
// scans the whole map. The first allocate or free after reset first clears the map.
// A new command is taken while a result waits on a stalled output.
`default_nettype none

module block_map_allocator (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire bma_pkg::in_item_t         in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output bma_pkg::out_item_t             out_item_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [bma_pkg::BB_W-1:0]  cfg_wdata_i
);

`include "block_map_allocator_macros.svh"

  localparam int unsigned PROD_W = bma_pkg::IDX_W + bma_pkg::BB_W;
  localparam int unsigned LIM_W  = bma_pkg::IDX_W + 1 + bma_pkg::BB_W;
  localparam int unsigned CMP_W  = (LIM_W > bma_pkg::SIZE_W) ? LIM_W : bma_pkg::SIZE_W;

  bma_pkg::state_e               state_q, state_d;
  bma_pkg::status_e              stat_q, stat_d;
  logic [bma_pkg::BB_W-1:0]      bb_q;
  logic [bma_pkg::BB_W-1:0]      eff_bb;
  logic                          map_ready_q, map_ready_d;

  logic [1:0]                    cmd_q;
  logic [bma_pkg::SIZE_W-1:0]    size_q;
  logic [bma_pkg::SIZE_W-1:0]    offset_q;

  logic [bma_pkg::IDX_W-1:0]     ptr_q, ptr_d;
  logic                          more_q, more_d;
  logic [bma_pkg::IDX_W-1:0]     chk_q, chk_d;
  logic                          pend_q, pend_d;
  logic [bma_pkg::CNT_W-1:0]     run_q, run_d;
  logic [bma_pkg::CNT_W-1:0]     need_q, need_d;
  logic [bma_pkg::CNT_W-1:0]     used_q, used_d;
  logic [bma_pkg::IDX_W-1:0]     fill_ptr_q, fill_ptr_d;
  logic [bma_pkg::CNT_W-1:0]     fill_cnt_q, fill_cnt_d;
  logic [bma_pkg::CNT_W-1:0]     fill_val_q, fill_val_d;
  logic [bma_pkg::IDX_W-1:0]     base_q, base_d;

  logic                          out_valid_q, out_valid_d;
  bma_pkg::out_item_t            out_q, out_d;
  logic                          out_load;

  logic [bma_pkg::CNT_W-1:0]     map_mem [bma_pkg::BLOCKS];
  logic [bma_pkg::CNT_W-1:0]     rd_data_q;
  logic                          mem_we;
  logic [bma_pkg::IDX_W-1:0]     mem_waddr;
  logic [bma_pkg::CNT_W-1:0]     mem_wdata;
  logic [bma_pkg::IDX_W-1:0]     mem_raddr;

  logic                          div_start;
  logic                          div_done;
  bma_pkg::div_res_t             div_res;
  logic [bma_pkg::SIZE_W-1:0]    div_dividend;

  logic                          in_accept;
  logic [bma_pkg::CNT_W-1:0]     run_nxt;
  logic                          need_hit;
  logic                          last_chk;
  logic                          too_big;
  logic                          offset_oob;
  logic [LIM_W-1:0]              pool_bytes;
  logic [bma_pkg::CNT_W-1:0]     room;
  logic [bma_pkg::CNT_W-1:0]     free_len;
  logic [PROD_W-1:0]             offs_prod;
  logic                          out_free;

  assign in_stall_o = state_q != bma_pkg::ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (bb_q == '0) begin
      eff_bb = bma_pkg::BB_W'(1);
    end else if (bb_q > bma_pkg::BB_W'(bma_pkg::BB_MAX)) begin
      eff_bb = bma_pkg::BB_W'(bma_pkg::BB_MAX);
    end else begin
      eff_bb = bb_q;
    end
  end

  assign div_dividend = (cmd_q == bma_pkg::CMD_FREE) ? offset_q : size_q;

  bma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (eff_bb),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // Read data in rd_data_q belongs to map index chk_q whenever pend_q is set.
  assign run_nxt  = (rd_data_q == '0) ? run_q + bma_pkg::CNT_W'(1) : '0;
  assign need_hit = pend_q && (run_nxt == need_q);
  assign last_chk = pend_q && (chk_q == '0);

  assign too_big = (div_res.quotient > bma_pkg::SIZE_W'(bma_pkg::BLOCKS)) ||
                   ((div_res.quotient == bma_pkg::SIZE_W'(bma_pkg::BLOCKS)) && div_res.rem_nz);

  assign pool_bytes = LIM_W'(bma_pkg::BLOCKS) * LIM_W'(eff_bb);
  assign offset_oob = CMP_W'(offset_q) >= CMP_W'(pool_bytes);

  // A free is clamped at the top of the map.
  assign room     = bma_pkg::CNT_W'(bma_pkg::BLOCKS) - bma_pkg::CNT_W'(fill_ptr_q);
  assign free_len = (rd_data_q > room) ? room : rd_data_q;

  assign offs_prod = PROD_W'(base_q) * PROD_W'(eff_bb);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bma_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bma_pkg::ST_DISPATCH;
        end
      end
      bma_pkg::ST_DISPATCH: begin
        case (cmd_q)
          bma_pkg::CMD_ALLOC: begin
            if (!map_ready_q) begin
              state_d = bma_pkg::ST_CLEAR;
            end else if (size_q == '0) begin
              state_d = bma_pkg::ST_RESP;
            end else begin
              state_d = bma_pkg::ST_DIV;
            end
          end
          bma_pkg::CMD_FREE: begin
            if (!map_ready_q) begin
              state_d = bma_pkg::ST_CLEAR;
            end else if (offset_oob) begin
              state_d = bma_pkg::ST_RESP;
            end else begin
              state_d = bma_pkg::ST_DIV;
            end
          end
          bma_pkg::CMD_QUERY: state_d = bma_pkg::ST_QUERY;
          default:            state_d = bma_pkg::ST_RESP;
        endcase
      end
      bma_pkg::ST_CLEAR: begin
        if (ptr_q == '0) begin
          // An allocate goes through dispatch again, now with a ready map.
          state_d = (cmd_q == bma_pkg::CMD_FREE) ? bma_pkg::ST_RESP : bma_pkg::ST_DISPATCH;
        end
      end
      bma_pkg::ST_DIV: begin
        if (div_done) begin
          if (cmd_q == bma_pkg::CMD_FREE) begin
            state_d = bma_pkg::ST_FREE_RD;
          end else if (too_big) begin
            state_d = bma_pkg::ST_RESP;
          end else begin
            state_d = bma_pkg::ST_SCAN;
          end
        end
      end
      bma_pkg::ST_SCAN: begin
        if (need_hit) begin
          state_d = bma_pkg::ST_FILL;
        end else if (last_chk) begin
          state_d = bma_pkg::ST_RESP;
        end
      end
      bma_pkg::ST_FILL: begin
        if (fill_cnt_q == bma_pkg::CNT_W'(1)) begin
          state_d = bma_pkg::ST_RESP;
        end
      end
      bma_pkg::ST_FREE_RD:  state_d = bma_pkg::ST_FREE_LEN;
      bma_pkg::ST_FREE_LEN: begin
        state_d = (free_len == '0) ? bma_pkg::ST_RESP : bma_pkg::ST_FILL;
      end
      bma_pkg::ST_QUERY: begin
        if (last_chk) begin
          state_d = bma_pkg::ST_RESP;
        end
      end
      bma_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = bma_pkg::ST_IDLE;
        end
      end
      default: state_d = bma_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory and divider control.
  always_comb begin
    stat_d      = stat_q;
    map_ready_d = map_ready_q;
    ptr_d       = ptr_q;
    more_d      = more_q;
    chk_d       = chk_q;
    pend_d      = 1'b0;
    run_d       = run_q;
    need_d      = need_q;
    used_d      = used_q;
    fill_ptr_d  = fill_ptr_q;
    fill_cnt_d  = fill_cnt_q;
    fill_val_d  = fill_val_q;
    base_d      = base_q;
    mem_we      = 1'b0;
    mem_waddr   = fill_ptr_q;
    mem_wdata   = fill_val_q;
    mem_raddr   = ptr_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      bma_pkg::ST_DISPATCH: begin
        ptr_d  = bma_pkg::IDX_W'(bma_pkg::BLOCKS - 1);
        more_d = 1'b1;
        run_d  = '0;
        used_d = '0;
        stat_d = bma_pkg::STAT_OK;
        case (cmd_q)
          bma_pkg::CMD_ALLOC: begin
            if (map_ready_q) begin
              if (size_q == '0) begin
                stat_d = bma_pkg::STAT_FAIL;
              end else begin
                div_start = 1'b1;
              end
            end
          end
          bma_pkg::CMD_FREE: begin
            if (map_ready_q) begin
              if (offset_oob) begin
                stat_d = bma_pkg::STAT_RANGE;
              end else begin
                div_start = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      bma_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = '0;
        ptr_d     = ptr_q - bma_pkg::IDX_W'(1);
        if (ptr_q == '0) begin
          map_ready_d = 1'b1;
          stat_d      = bma_pkg::STAT_NOT_READY;
        end
      end
      bma_pkg::ST_DIV: begin
        if (div_done) begin
          if (cmd_q == bma_pkg::CMD_FREE) begin
            fill_ptr_d = div_res.quotient[bma_pkg::IDX_W-1:0];
          end else if (too_big) begin
            stat_d = bma_pkg::STAT_FAIL;
          end else begin
            need_d = bma_pkg::CNT_W'(div_res.quotient) + bma_pkg::CNT_W'(div_res.rem_nz);
          end
        end
      end
      bma_pkg::ST_SCAN: begin
        if (more_q) begin
          ptr_d  = ptr_q - bma_pkg::IDX_W'(1);
          more_d = ptr_q != '0;
          chk_d  = ptr_q;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          run_d = run_nxt;
          if (need_hit) begin
            fill_ptr_d = chk_q;
            base_d     = chk_q;
            fill_cnt_d = need_q;
            fill_val_d = need_q;
          end else if (chk_q == '0) begin
            stat_d = bma_pkg::STAT_FAIL;
          end
        end
      end
      bma_pkg::ST_FILL: begin
        mem_we     = 1'b1;
        fill_ptr_d = fill_ptr_q + bma_pkg::IDX_W'(1);
        fill_cnt_d = fill_cnt_q - bma_pkg::CNT_W'(1);
      end
      bma_pkg::ST_FREE_RD: begin
        mem_raddr = fill_ptr_q;
      end
      bma_pkg::ST_FREE_LEN: begin
        fill_cnt_d = free_len;
        fill_val_d = '0;
      end
      bma_pkg::ST_QUERY: begin
        if (more_q) begin
          ptr_d  = ptr_q - bma_pkg::IDX_W'(1);
          more_d = ptr_q != '0;
          chk_d  = ptr_q;
          pend_d = 1'b1;
        end
        if (pend_q && (rd_data_q != '0)) begin
          used_d = used_q + bma_pkg::CNT_W'(1);
        end
      end
      bma_pkg::ST_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d        = 1'b1;
      out_d.status       = stat_q;
      out_d.alloc_offset = '0;
      out_d.used_blocks  = '0;
      if ((cmd_q == bma_pkg::CMD_ALLOC) && (stat_q == bma_pkg::STAT_OK)) begin
        out_d.alloc_offset = bma_pkg::SIZE_W'(offs_prod);
      end
      if (cmd_q == bma_pkg::CMD_QUERY) begin
        out_d.used_blocks = bma_pkg::USED_W'(used_q);
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bma_pkg::ST_IDLE;
      map_ready_q <= 1'b0;
      bb_q        <= bma_pkg::BB_RESET;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      map_ready_q <= map_ready_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        bb_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= in_item_i.command;
      size_q   <= in_item_i.size_bytes;
      offset_q <= in_item_i.offset_bytes;
    end
    stat_q     <= stat_d;
    ptr_q      <= ptr_d;
    chk_q      <= chk_d;
    run_q      <= run_d;
    need_q     <= need_d;
    used_q     <= used_d;
    fill_ptr_q <= fill_ptr_d;
    fill_cnt_q <= fill_cnt_d;
    fill_val_q <= fill_val_d;
    base_q     <= base_d;
    out_q      <= out_d;
  end

  // Map memory: clears and fills write it, scans and free lookups read it.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= map_mem[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `BMA_ASSERT(a_no_write_idle, state_q == bma_pkg::ST_IDLE |-> !mem_we)
  `BMA_ASSERT(a_fill_in_map, state_q == bma_pkg::ST_FILL |-> fill_cnt_q != '0 && fill_cnt_q <= room)
  `BMA_ASSERT(a_ready_stays, map_ready_q |=> map_ready_q)
  `BMA_ASSERT(a_div_done_in_div, div_done |-> state_q == bma_pkg::ST_DIV)
  `BMA_ASSERT(a_scan_need, state_q == bma_pkg::ST_SCAN |-> need_q != '0 && need_q <= bma_pkg::CNT_W'(bma_pkg::BLOCKS))
  `BMA_ASSERT_RST(a_reset_idle, !rst_ni |=> state_q == bma_pkg::ST_IDLE && !out_valid_q)

endmodule

`default_nettype wire
